>>> hw/rtl/txu_pkg.sv
package txu_pkg;

    // layout codes of the configuration register
    typedef enum logic [3:0] {
        LAYOUT_8888REV  = 4'd0,
        LAYOUT_1010102B = 4'd1,
        LAYOUT_1010102R = 4'd2,
        LAYOUT_4444REV  = 4'd3,
        LAYOUT_1555REV  = 4'd4,
        LAYOUT_565      = 4'd5,
        LAYOUT_L8       = 4'd6,
        LAYOUT_A8       = 4'd7,
        LAYOUT_LA8      = 4'd8,
        LAYOUT_BGR8     = 4'd9,
        LAYOUT_RGB8     = 4'd10,
        LAYOUT_BGRA8    = 4'd11,
        LAYOUT_RGBA8    = 4'd12,
        LAYOUT_RGBA16   = 4'd13
    } layout_t;

    localparam logic [3:0] LAYOUT_RESET = 4'd12;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned BYTES_W = 4;

    // one expanded texel
    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [BYTES_W-1:0] texel_bytes;
    } rgba8_t;

    // floor(v * 255 / 31) for a 5-bit channel
    localparam logic [7:0] WIDEN5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage

>>> hw/rtl/txu_in_reg.sv
module txu_in_reg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [txu_pkg::WORD_W-1:0]     up_word,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic [txu_pkg::WORD_W-1:0]     dn_word
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [txu_pkg::WORD_W-1:0] word_reg;

    // stage takes a new transaction when empty or draining this cycle
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_valid || (valid_reg && !dn_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            word_reg <= up_word;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

>>> hw/rtl/txu_decode.sv
module txu_decode
(
    input  logic [3:0]                 layout,
    input  logic [txu_pkg::WORD_W-1:0] word,
    output txu_pkg::rgba8_t            texel
);

    // floor(v * 255 / 63) = 4v + floor(v / 21)
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] corr;
        begin
            if (v == 6'd63)
            begin
                corr = 2'd3;
            end
            else if (v >= 6'd42)
            begin
                corr = 2'd2;
            end
            else if (v >= 6'd21)
            begin
                corr = 2'd1;
            end
            else
            begin
                corr = 2'd0;
            end
            widen6 = {v, 2'b00} + {6'd0, corr};
        end
    endfunction

    logic [7:0] b0, b1, b2, b3, b5, b7;
    logic [7:0] c0, c1, c2, a2;

    assign b0 = word[7:0];
    assign b1 = word[15:8];
    assign b2 = word[23:16];
    assign b3 = word[31:24];
    assign b5 = word[47:40];
    assign b7 = word[63:56];

    // 10-bit channels keep their top byte, 2-bit alpha scales by 85
    assign c0 = word[31:24];
    assign c1 = word[21:14];
    assign c2 = word[11:4];
    assign a2 = {word[1:0], word[1:0], word[1:0], word[1:0]};

    // per-layout channel selection
    always_comb
    begin
        texel.red         = b0;
        texel.green       = b1;
        texel.blue        = b2;
        texel.alpha       = b3;
        texel.texel_bytes = 4'd4;
        case (txu_pkg::layout_t'(layout))
            txu_pkg::LAYOUT_8888REV,
            txu_pkg::LAYOUT_BGRA8:
            begin
                texel.red   = b2;
                texel.blue  = b0;
            end
            txu_pkg::LAYOUT_1010102B:
            begin
                texel.red   = c2;
                texel.green = c1;
                texel.blue  = c0;
                texel.alpha = a2;
            end
            txu_pkg::LAYOUT_1010102R:
            begin
                texel.red   = c0;
                texel.green = c1;
                texel.blue  = c2;
                texel.alpha = a2;
            end
            txu_pkg::LAYOUT_4444REV:
            begin
                texel.red         = {word[11:8], word[11:8]};
                texel.green       = {word[7:4], word[7:4]};
                texel.blue        = {word[3:0], word[3:0]};
                texel.alpha       = {word[15:12], word[15:12]};
                texel.texel_bytes = 4'd2;
            end
            txu_pkg::LAYOUT_1555REV:
            begin
                texel.red         = txu_pkg::WIDEN5_LUT[word[14:10]];
                texel.green       = txu_pkg::WIDEN5_LUT[word[9:5]];
                texel.blue        = txu_pkg::WIDEN5_LUT[word[4:0]];
                texel.alpha       = {8{word[15]}};
                texel.texel_bytes = 4'd2;
            end
            txu_pkg::LAYOUT_565:
            begin
                texel.red         = txu_pkg::WIDEN5_LUT[word[15:11]];
                texel.green       = widen6(word[10:5]);
                texel.blue        = txu_pkg::WIDEN5_LUT[word[4:0]];
                texel.alpha       = 8'hFF;
                texel.texel_bytes = 4'd2;
            end
            txu_pkg::LAYOUT_L8:
            begin
                texel.green       = b0;
                texel.blue        = b0;
                texel.alpha       = 8'hFF;
                texel.texel_bytes = 4'd1;
            end
            txu_pkg::LAYOUT_A8:
            begin
                texel.red         = 8'd0;
                texel.green       = 8'd0;
                texel.blue        = 8'd0;
                texel.alpha       = b0;
                texel.texel_bytes = 4'd1;
            end
            txu_pkg::LAYOUT_LA8:
            begin
                texel.green       = b0;
                texel.blue        = b0;
                texel.alpha       = b1;
                texel.texel_bytes = 4'd2;
            end
            txu_pkg::LAYOUT_BGR8:
            begin
                texel.red         = b2;
                texel.blue        = b0;
                texel.alpha       = 8'hFF;
                texel.texel_bytes = 4'd3;
            end
            txu_pkg::LAYOUT_RGB8:
            begin
                texel.alpha       = 8'hFF;
                texel.texel_bytes = 4'd3;
            end
            txu_pkg::LAYOUT_RGBA16:
            begin
                texel.red         = b1;
                texel.green       = b3;
                texel.blue        = b5;
                texel.alpha       = b7;
                texel.texel_bytes = 4'd8;
            end
            default:
            begin
                // rgba8 and the unused codes keep the plain byte order
                texel.texel_bytes = 4'd4;
            end
        endcase
    end

endmodule

>>> hw/rtl/txu_out_reg.sv
module txu_out_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  txu_pkg::rgba8_t up_texel,
    output logic            dn_valid,
    input  logic            dn_ready,
    output txu_pkg::rgba8_t dn_texel
);

    logic            valid_reg;
    logic            valid_next;
    txu_pkg::rgba8_t texel_reg;

    // result register frees up when empty or taken this cycle
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_valid || (valid_reg && !dn_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            texel_reg <= up_texel;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_texel = texel_reg;

endmodule

>>> hw/rtl/texel_unpack_rgba8_core.sv
// a texel is held in the input register, decoded combinationally and held again in the result register
// throughput: one texel per cycle while result_ready stays high, set by the input register and the result register
// each registered stage accepts a new transaction when empty or while its own is taken downstream
// reset: both stages empty, layout register set to rgba8
module texel_unpack_rgba8_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [3:0]                      cfg_wdata,
    input  logic                            texel_valid,
    output logic                            texel_ready,
    input  logic [txu_pkg::WORD_W-1:0]      texel_word,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [txu_pkg::CHAN_W-1:0]      red,
    output logic [txu_pkg::CHAN_W-1:0]      green,
    output logic [txu_pkg::CHAN_W-1:0]      blue,
    output logic [txu_pkg::CHAN_W-1:0]      alpha,
    output logic [txu_pkg::BYTES_W-1:0]     texel_bytes
);

    logic [3:0]                 layout_reg;
    logic                       s1_valid;
    logic                       s1_ready;
    logic [txu_pkg::WORD_W-1:0] s1_word;
    txu_pkg::rgba8_t            dec_texel;
    txu_pkg::rgba8_t            out_texel;

    // layout configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= txu_pkg::LAYOUT_RESET;
        end
        else if (cfg_we)
        begin
            layout_reg <= cfg_wdata;
        end
    end

    // input register
    txu_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (texel_valid),
        .up_ready (texel_ready),
        .up_word  (texel_word),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_word  (s1_word)
    );

    // channel extraction and scaling
    txu_decode u_decode
    (
        .layout (layout_reg),
        .word   (s1_word),
        .texel  (dec_texel)
    );

    // result register
    txu_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_texel (dec_texel),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_texel (out_texel)
    );

    assign red         = out_texel.red;
    assign green       = out_texel.green;
    assign blue        = out_texel.blue;
    assign alpha       = out_texel.alpha;
    assign texel_bytes = out_texel.texel_bytes;

    // a texel moving out of the input register shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s1_ready |=> result_valid)
        else $error("texel lost between input and result register");

    // input side only stalls while the input register holds a texel
    assert property (@(posedge clk) disable iff (!rst_n)
        !texel_ready |-> s1_valid)
        else $error("input stalled with empty input register");

    // reported texel size is one of the defined sizes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (texel_bytes == 4'd1 || texel_bytes == 4'd2 ||
                          texel_bytes == 4'd3 || texel_bytes == 4'd4 ||
                          texel_bytes == 4'd8))
        else $error("invalid texel size on result");

endmodule
